// ===== hw/rtl/mswg_pkg.sv =====
// Shared types, codes and widths of the multi-shape waveform generator.
package mswg_pkg;

    localparam int PHASE_W = 32;
    localparam int FREQ_W  = 15;
    localparam int GAIN_W  = 17;
    localparam int CFG_W   = 17;
    localparam int TIME_W  = 32;
    localparam int DAC_W   = 12;

    typedef logic [2:0] shape_t;

    localparam shape_t SHAPE_SILENCE  = 3'd0;
    localparam shape_t SHAPE_SINE     = 3'd1;
    localparam shape_t SHAPE_SQUARE   = 3'd2;
    localparam shape_t SHAPE_TRIANGLE = 3'd3;
    localparam shape_t SHAPE_SAWTOOTH = 3'd4;
    localparam shape_t SHAPE_SEQUENCE = 3'd5;

    typedef logic [1:0] reg_idx_t;

    localparam reg_idx_t REG_FREQUENCY = 2'd0;
    localparam reg_idx_t REG_SHAPE     = 2'd1;
    localparam reg_idx_t REG_AMPLITUDE = 2'd2;

    typedef struct packed {
        shape_t               kind;
        logic [PHASE_W-1:0]   phase;
    } work_t;

endpackage

// ===== hw/rtl/mswg_front.sv =====
// Front end: configuration registers, phase increment multiplier, phases and sequence control.
module mswg_front #(
    parameter int SAMPLE_RATE_HZ = 48000
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  mswg_pkg::reg_idx_t            cfg_index,
    input  logic [mswg_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mswg_pkg::TIME_W-1:0]   now_ms,
    input  logic                          last_of_buffer,
    output logic                          push,
    output mswg_pkg::work_t               push_word,
    input  logic                          full,
    output logic [mswg_pkg::GAIN_W-1:0]   gain
);
    import mswg_pkg::*;

    localparam int RECIP_SHIFT = FREQ_W + $clog2(SAMPLE_RATE_HZ);
    localparam int RECIP_W     = 48;
    localparam int HALF_W      = RECIP_W / 2;
    localparam int PART_W      = FREQ_W + HALF_W;
    localparam int ACC_W       = FREQ_W + RECIP_W;
    localparam logic [127:0] RECIP_WIDE =
        ((128'd1 << (PHASE_W + RECIP_SHIFT)) + 128'(SAMPLE_RATE_HZ - 1))
        / 128'(SAMPLE_RATE_HZ);
    localparam logic [HALF_W-1:0] RECIP_LO = RECIP_WIDE[HALF_W-1:0];
    localparam logic [HALF_W-1:0] RECIP_HI = RECIP_WIDE[RECIP_W-1:HALF_W];

    localparam logic [FREQ_W-1:0] FREQ_RESET = 15'd880;
    localparam logic [FREQ_W-1:0] FREQ_MAX   = 15'd22000;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd60293;
    localparam logic [GAIN_W-1:0] GAIN_MAX   = 17'd65536;
    localparam logic [63:0] INC_RESET_WIDE =
        (64'(FREQ_RESET) << PHASE_W) / 64'(SAMPLE_RATE_HZ);
    localparam logic [PHASE_W-1:0] INC_RESET = INC_RESET_WIDE[PHASE_W-1:0];
    localparam logic [PHASE_W-1:0] PHASE_HALF = 32'h8000_0000;

    localparam logic [1:0] SEQ_LEAD  = 2'd0;
    localparam logic [1:0] SEQ_WAIT  = 2'd1;
    localparam logic [1:0] SEQ_PULSE = 2'd2;
    localparam logic [1:0] SEQ_REST  = 2'd3;

    localparam logic [TIME_W-1:0] WAIT_MS  = 32'd100;
    localparam logic [TIME_W-1:0] PULSE_MS = 32'd105;
    localparam logic [TIME_W-1:0] REST_MS  = 32'd1000;

    shape_t               shape_reg, shape_next;
    logic [GAIN_W-1:0]    gain_reg, gain_next;
    logic [PHASE_W-1:0]   inc_reg, inc_next;
    logic [PHASE_W-1:0]   sine_reg, sine_next;
    logic [PHASE_W-1:0]   square_reg, square_next;
    logic [PHASE_W-1:0]   tri_reg, tri_next;
    logic [PHASE_W-1:0]   saw_reg, saw_next;
    logic [1:0]           step_reg, step_next;
    logic [TIME_W-1:0]    pulse_reg, pulse_next;

    logic                 inc_busy_reg, inc_busy_next;
    logic                 inc_low_reg, inc_low_next;
    logic [FREQ_W-1:0]    inc_num_reg, inc_num_next;
    logic [ACC_W-1:0]     inc_acc_reg, inc_acc_next;

    logic [PART_W-1:0]    part;
    logic [ACC_W-1:0]     acc_sum;
    logic                 accept;
    logic [TIME_W-1:0]    elapsed;
    logic [FREQ_W-1:0]    wr_freq;
    shape_t               wr_shape;
    logic [GAIN_W-1:0]    wr_gain;

    assign in_stall = full || inc_busy_reg;
    assign accept   = in_valid && !in_stall;
    assign gain     = gain_reg;
    assign elapsed  = now_ms - pulse_reg;
    assign part     = PART_W'(inc_num_reg) * PART_W'(inc_low_reg ? RECIP_LO : RECIP_HI);
    assign acc_sum  = {inc_acc_reg[ACC_W-HALF_W-1:0], {HALF_W{1'b0}}} + ACC_W'(part);
    assign wr_freq  = cfg_wdata[FREQ_W-1:0];
    assign wr_shape = cfg_wdata[2:0];
    assign wr_gain  = cfg_wdata[GAIN_W-1:0];

    always_comb
    begin
        shape_next    = shape_reg;
        gain_next     = gain_reg;
        inc_next      = inc_reg;
        sine_next     = sine_reg;
        square_next   = square_reg;
        tri_next      = tri_reg;
        saw_next      = saw_reg;
        step_next     = step_reg;
        pulse_next    = pulse_reg;
        inc_busy_next = inc_busy_reg;
        inc_low_next  = inc_low_reg;
        inc_num_next  = inc_num_reg;
        inc_acc_next  = inc_acc_reg;
        push          = accept;
        push_word     = '{kind: SHAPE_SILENCE, phase: '0};

        // multiply by the rate reciprocal, upper half first
        if (inc_busy_reg)
        begin
            inc_acc_next = acc_sum;
            inc_low_next = 1'b1;
            if (inc_low_reg)
            begin
                inc_busy_next = 1'b0;
                inc_next      = PHASE_W'(acc_sum >> RECIP_SHIFT);
            end
        end

        if (accept)
        begin
            case (shape_reg)
                SHAPE_SINE:
                begin
                    push_word = '{kind: SHAPE_SINE, phase: sine_reg};
                    sine_next = sine_reg + inc_reg;
                end
                SHAPE_SQUARE:
                begin
                    push_word   = '{kind: SHAPE_SQUARE, phase: square_reg};
                    square_next = square_reg + inc_reg;
                end
                SHAPE_TRIANGLE:
                begin
                    push_word = '{kind: SHAPE_TRIANGLE, phase: tri_reg};
                    tri_next  = tri_reg + inc_reg;
                end
                SHAPE_SAWTOOTH:
                begin
                    push_word = '{kind: SHAPE_SAWTOOTH, phase: saw_reg};
                    saw_next  = saw_reg + inc_reg;
                end
                SHAPE_SEQUENCE:
                begin
                    if (step_reg == SEQ_PULSE)
                    begin
                        push_word = '{kind: SHAPE_SINE, phase: sine_reg};
                        sine_next = sine_reg + inc_reg;
                    end
                    if (last_of_buffer)
                    begin
                        unique case (step_reg)
                            SEQ_LEAD:
                            begin
                                sine_next  = '0;
                                pulse_next = now_ms;
                                step_next  = SEQ_WAIT;
                            end
                            SEQ_WAIT:
                                if (elapsed > WAIT_MS)
                                    step_next = SEQ_PULSE;
                            SEQ_PULSE:
                                if (elapsed > PULSE_MS)
                                    step_next = SEQ_REST;
                            SEQ_REST:
                                if (elapsed > REST_MS)
                                    step_next = SEQ_LEAD;
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FREQUENCY:
                    if (wr_freq != '0 && wr_freq <= FREQ_MAX)
                    begin
                        inc_busy_next = 1'b1;
                        inc_low_next  = 1'b0;
                        inc_num_next  = wr_freq;
                        inc_acc_next  = '0;
                    end
                REG_SHAPE:
                    if (wr_shape <= SHAPE_SEQUENCE)
                    begin
                        shape_next = wr_shape;
                        case (wr_shape)
                            SHAPE_SINE:     sine_next   = '0;
                            SHAPE_SQUARE:   square_next = '0;
                            SHAPE_TRIANGLE: tri_next    = PHASE_HALF;
                            SHAPE_SAWTOOTH: saw_next    = PHASE_HALF;
                            SHAPE_SEQUENCE: step_next   = SEQ_LEAD;
                            default:
                            begin
                            end
                        endcase
                    end
                REG_AMPLITUDE:
                    if (wr_gain <= GAIN_MAX)
                        gain_next = wr_gain;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg    <= SHAPE_SINE;
            gain_reg     <= GAIN_RESET;
            inc_reg      <= INC_RESET;
            sine_reg     <= '0;
            square_reg   <= '0;
            tri_reg      <= PHASE_HALF;
            saw_reg      <= PHASE_HALF;
            step_reg     <= SEQ_LEAD;
            pulse_reg    <= '0;
            inc_busy_reg <= 1'b0;
            inc_low_reg  <= 1'b0;
        end
        else
        begin
            shape_reg    <= shape_next;
            gain_reg     <= gain_next;
            inc_reg      <= inc_next;
            sine_reg     <= sine_next;
            square_reg   <= square_next;
            tri_reg      <= tri_next;
            saw_reg      <= saw_next;
            step_reg     <= step_next;
            pulse_reg    <= pulse_next;
            inc_busy_reg <= inc_busy_next;
            inc_low_reg  <= inc_low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inc_num_reg <= inc_num_next;
        inc_acc_reg <= inc_acc_next;
    end

    a_inc_start: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == REG_FREQUENCY && wr_freq != '0 && wr_freq <= FREQ_MAX
        |=> inc_busy_reg)
        else $error("increment update did not start on frequency write");

    a_inc_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        inc_busy_reg |-> in_stall && !accept)
        else $error("item taken while increment is being computed");

    a_seq_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cfg_we && shape_reg == SHAPE_SEQUENCE && step_reg == SEQ_LEAD
        && last_of_buffer |=> step_reg == SEQ_WAIT && sine_reg == '0)
        else $error("sequence failed to leave lead-in step");

endmodule

// ===== hw/rtl/mswg_queue.sv =====
// Short queue of classified words between front end and sample unit.
module mswg_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mswg_pkg::work_t  push_word,
    output logic             full,
    input  logic             pop,
    output logic             ready_word,
    output mswg_pkg::work_t  pop_word
);
    import mswg_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    work_t              mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign ready_word = count_reg != '0;
    assign pop_word   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && ready_word;

    always_comb
    begin
        wr_ptr_next = do_push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_word;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("word pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> ready_word)
        else $error("word popped from empty queue");

    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 || count_reg == CNT_W'(DEPTH) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with fill count");

endmodule

// ===== hw/rtl/mswg_back.sv =====
// Sample unit: shared multiplier sequence, rounding, clamping and output register.
module mswg_back #(
    parameter int DAC_FULL_SCALE   = 4095,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          ready_word,
    input  mswg_pkg::work_t               pop_word,
    output logic                          pop,
    input  logic [mswg_pkg::GAIN_W-1:0]   gain,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mswg_pkg::DAC_W-1:0]    dac_code
);
    import mswg_pkg::*;

    localparam int OP_W   = 33;
    localparam int PROD_W = 2 * OP_W;
    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam logic [PHASE_W-1:0] IDX_MASK = ~(32'hFFFF_FFFF >> IDX_W);
    localparam int MID = (DAC_FULL_SCALE + 1) / 2;
    localparam logic [OP_W-1:0]   MID_OP = OP_W'(MID);
    localparam logic [OP_W-1:0]   FS_OP  = OP_W'(DAC_FULL_SCALE);
    localparam logic [PROD_W-1:0] MID_W  = PROD_W'(MID);
    localparam logic [PROD_W-1:0] FS_W   = PROD_W'(DAC_FULL_SCALE);
    localparam logic [PHASE_W-1:0] Q30   = 32'h4000_0000;
    localparam logic [17:0] Q16_ONE = 18'd65536;
    localparam logic [17:0] SIN_C1  = 18'd102944;
    localparam logic [17:0] SIN_C2  = 18'd42334;
    localparam logic [17:0] SIN_C3  = 18'd4926;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [2:0]          step_reg, step_next;
    shape_t              kind_reg, kind_next;
    logic                neg_reg, neg_next;
    logic [16:0]         u_reg, u_next;
    logic [16:0]         u2_reg, u2_next;
    logic [PHASE_W-1:0]  m_reg, m_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic                out_valid_reg, out_valid_next;
    logic [DAC_W-1:0]    dac_reg, dac_next;

    logic [PHASE_W-1:0]  q_phase;
    logic [16:0]         u_load;
    logic [PHASE_W-1:0]  abs_p;
    logic                tri_neg;
    logic [PHASE_W-1:0]  tri_m;
    logic [OP_W-1:0]     op_a;
    logic [OP_W-1:0]     op_b;
    logic [PROD_W-1:0]   prod;
    logic [17:0]         sin_t;
    logic [17:0]         sin_s;
    logic                last_step;
    logic [PROD_W-1:0]   fl;
    logic                frac;
    logic [PROD_W-1:0]   ce;
    logic [PROD_W-1:0]   v;
    logic                fin_go;

    assign q_phase = pop_word.phase & IDX_MASK;
    assign u_load  = q_phase[30] ? 17'(Q16_ONE - {2'b00, q_phase[29:14]})
                                 : {1'b0, q_phase[29:14]};
    assign abs_p   = pop_word.phase[31] ? (32'd0 - pop_word.phase) : pop_word.phase;
    assign tri_neg = abs_p > Q30;
    assign tri_m   = tri_neg ? abs_p - Q30 : Q30 - abs_p;
    assign sin_t   = acc_reg[33:16];
    assign sin_s   = (sin_t > Q16_ONE) ? Q16_ONE : sin_t;
    assign prod    = PROD_W'(op_a) * PROD_W'(op_b);
    assign fin_go  = state_reg == ST_FIN && (!out_valid_reg || !out_stall);
    assign pop     = state_reg == ST_IDLE && ready_word;
    assign out_valid = out_valid_reg;
    assign dac_code  = dac_reg;

    always_comb
    begin
        op_a      = '0;
        op_b      = '0;
        last_step = 1'b1;
        unique case (kind_reg)
            SHAPE_SINE:
            begin
                last_step = step_reg == 3'd5;
                unique case (step_reg)
                    3'd0:
                    begin
                        op_a = OP_W'(u_reg);
                        op_b = OP_W'(u_reg);
                    end
                    3'd1:
                    begin
                        op_a = OP_W'(acc_reg[32:16]);
                        op_b = OP_W'(SIN_C3);
                    end
                    3'd2:
                    begin
                        op_a = OP_W'(u2_reg);
                        op_b = OP_W'(SIN_C2 - {1'b0, acc_reg[32:16]});
                    end
                    3'd3:
                    begin
                        op_a = OP_W'(u_reg);
                        op_b = OP_W'(SIN_C1 - sin_t);
                    end
                    3'd4:
                    begin
                        op_a = OP_W'(sin_s);
                        op_b = OP_W'(gain);
                    end
                    default:
                    begin
                        op_a = acc_reg[OP_W-1:0];
                        op_b = MID_OP;
                    end
                endcase
            end
            SHAPE_SQUARE:
            begin
                op_a = MID_OP;
                op_b = OP_W'(gain);
            end
            SHAPE_TRIANGLE, SHAPE_SAWTOOTH:
            begin
                last_step = step_reg == 3'd1;
                if (step_reg == 3'd0)
                begin
                    op_a = (kind_reg == SHAPE_TRIANGLE) ? MID_OP : FS_OP;
                    op_b = OP_W'(gain);
                end
                else
                begin
                    op_a = acc_reg[OP_W-1:0];
                    op_b = OP_W'(m_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        unique case (kind_reg)
            SHAPE_SINE:
            begin
                fl   = acc_reg >> 32;
                frac = |acc_reg[31:0];
            end
            SHAPE_SQUARE:
            begin
                fl   = acc_reg >> 16;
                frac = |acc_reg[15:0];
            end
            SHAPE_TRIANGLE:
            begin
                fl   = acc_reg >> 46;
                frac = |acc_reg[45:0];
            end
            SHAPE_SAWTOOTH:
            begin
                fl   = acc_reg >> 48;
                frac = |acc_reg[47:0];
            end
            default:
            begin
                fl   = '0;
                frac = 1'b0;
            end
        endcase
        ce = fl + PROD_W'(frac);
        if (neg_reg)
            v = (MID_W >= ce) ? MID_W - ce : '0;
        else
            v = MID_W + fl;
        if (v > FS_W)
            v = FS_W;
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        kind_next      = kind_reg;
        neg_next       = neg_reg;
        u_next         = u_reg;
        u2_next        = u2_reg;
        m_next         = m_reg;
        acc_next       = acc_reg;
        dac_next       = dac_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
                if (ready_word)
                begin
                    kind_next = pop_word.kind;
                    u_next    = u_load;
                    m_next    = (pop_word.kind == SHAPE_TRIANGLE) ? tri_m : abs_p;
                    step_next = '0;
                    acc_next  = '0;
                    unique case (pop_word.kind)
                        SHAPE_SINE:     neg_next = q_phase[31];
                        SHAPE_SQUARE:   neg_next = pop_word.phase[31];
                        SHAPE_TRIANGLE: neg_next = tri_neg;
                        SHAPE_SAWTOOTH: neg_next = pop_word.phase[31];
                        default:        neg_next = 1'b0;
                    endcase
                    state_next = (pop_word.kind == SHAPE_SILENCE) ? ST_FIN : ST_MUL;
                end
            ST_MUL:
            begin
                acc_next  = prod;
                step_next = step_reg + 3'd1;
                if (kind_reg == SHAPE_SINE && step_reg == 3'd1)
                    u2_next = acc_reg[32:16];
                if (last_step)
                    state_next = ST_FIN;
            end
            ST_FIN:
                if (fin_go)
                begin
                    dac_next       = v[DAC_W-1:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            kind_reg      <= SHAPE_SILENCE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        u_reg   <= u_next;
        u2_reg  <= u2_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
        dac_reg <= dac_next;
    end

    a_silence_direct: assert property (@(posedge clk) disable iff (!rst_n)
        pop && pop_word.kind == SHAPE_SILENCE |=> state_reg == ST_FIN && acc_reg == '0)
        else $error("silent word did not go straight to output");

    a_mul_kind: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |-> kind_reg != SHAPE_SILENCE && step_reg <= 3'd5)
        else $error("multiply step out of sequence");

    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("finished sample not presented");

endmodule

// ===== hw/rtl/multi_shape_waveform_generator.sv =====
// Top level of the multi-shape waveform generator: front end, queue and sample unit.
// The sample unit works on one word at a time, using a shared 33x33 multiplier; the queue
// lets the front end accept new words while the sample unit is busy, until the queue is full.
// A frequency write runs a two-step reciprocal multiply and holds the input until it is done.
// Reset sets the configuration, phase, pointer and state registers at once to their power-on
// values; datapath registers and queue storage are not reset, and there is no clearing pass.
module multi_shape_waveform_generator #(
    parameter int SAMPLE_RATE_HZ   = 48000,
    parameter int DAC_FULL_SCALE   = 4095,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  mswg_pkg::reg_idx_t            cfg_index,
    input  logic [mswg_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mswg_pkg::TIME_W-1:0]   now_ms,
    input  logic                          last_of_buffer,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mswg_pkg::DAC_W-1:0]    dac_code
);
    import mswg_pkg::*;

    logic                push;
    work_t               push_word;
    logic                full;
    logic                pop;
    logic                ready_word;
    work_t               pop_word;
    logic [GAIN_W-1:0]   gain;

    mswg_front #(
        .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .now_ms         (now_ms),
        .last_of_buffer (last_of_buffer),
        .push           (push),
        .push_word      (push_word),
        .full           (full),
        .gain           (gain)
    );

    mswg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (push_word),
        .full       (full),
        .pop        (pop),
        .ready_word (ready_word),
        .pop_word   (pop_word)
    );

    mswg_back #(
        .DAC_FULL_SCALE   (DAC_FULL_SCALE),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ready_word (ready_word),
        .pop_word   (pop_word),
        .pop        (pop),
        .gain       (gain),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .dac_code   (dac_code)
    );

endmodule

// ===== tb/tb_multi_shape_waveform_generator.sv =====
// Testbench of the multi-shape waveform generator: predicted DAC codes checked word by word.
module tb_multi_shape_waveform_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import mswg_pkg::*;

    localparam int SAMPLE_RATE    = 48000;
    localparam int FULL_SCALE     = 4095;
    localparam int TABLE_DEPTH    = 1024;
    localparam int PHASE_COUNT    = 12;
    localparam int PHASE_WORDS    = 95;
    localparam int DRAIN_CYCLES   = 16;
    localparam int DIVIDE_CYCLES  = 50;
    localparam int HOLD_CYCLES    = 300;
    localparam logic [31:0] SEQ_BASE_MS = 32'hFFFF_FFC0;

    class dac_sample_board;
        typedef enum logic [1:0] {SEQ_WAIT, SEQ_LEAD, SEQ_BURST, SEQ_TAIL} seq_state_e;

        localparam logic [63:0] MID  = (FULL_SCALE + 1) / 2;
        localparam logic [63:0] FULL = FULL_SCALE;
        localparam logic [63:0] Q30  = 64'h4000_0000;
        localparam logic [31:0] HALF = 32'h8000_0000;

        logic [FREQ_W-1:0] freq;
        shape_t            shape;
        logic [GAIN_W-1:0] gain;
        logic [31:0]       sine_ph;
        logic [31:0]       square_ph;
        logic [31:0]       tri_ph;
        logic [31:0]       saw_ph;
        seq_state_e        seq_state;
        logic [31:0]       pulse_start;
        logic [DAC_W-1:0]  expected_codes[$];
        int                errors;

        function new();
            freq        = 15'd880;
            shape       = SHAPE_SINE;
            gain        = 17'd60293;
            sine_ph     = 32'd0;
            square_ph   = 32'd0;
            tri_ph      = HALF;
            saw_ph      = HALF;
            seq_state   = SEQ_WAIT;
            pulse_start = 32'd0;
            errors      = 0;
        endfunction

        function logic [DAC_W-1:0] centered_code(logic [63:0] num, bit neg, int sh);
            logic [63:0] fl;
            logic [63:0] ce;
            logic [63:0] v;
            logic [63:0] mask;
            fl   = num >> sh;
            mask = (64'd1 << sh) - 64'd1;
            if (neg)
            begin
                ce = fl + (((num & mask) != 64'd0) ? 64'd1 : 64'd0);
                v  = (MID >= ce) ? MID - ce : 64'd0;
            end
            else
            begin
                v = MID + fl;
            end
            if (v > FULL)
                v = FULL;
            return v[DAC_W-1:0];
        endfunction

        function logic [63:0] quarter_sine(logic [63:0] u);
            logic [63:0] u2;
            logic [63:0] t;
            u2 = (u * u) >> 16;
            t  = (u2 * 64'd4926) >> 16;
            t  = 64'd42334 - t;
            t  = (u2 * t) >> 16;
            t  = 64'd102944 - t;
            t  = (u * t) >> 16;
            return (t > 64'd65536) ? 64'd65536 : t;
        endfunction

        function logic [DAC_W-1:0] sine_code();
            logic [63:0] idx;
            logic [63:0] q;
            logic [63:0] u;
            logic [63:0] s;
            logic [1:0]  quad;
            idx  = ({32'd0, sine_ph} * TABLE_DEPTH) >> 32;
            q    = (idx << 32) / TABLE_DEPTH;
            quad = q[31:30];
            u    = (q >> 14) & 64'hFFFF;
            if (quad[0])
                u = 64'd65536 - u;
            s = quarter_sine(u);
            return centered_code(MID * s * {47'd0, gain}, quad[1], 32);
        endfunction

        function logic [31:0] phase_inc();
            logic [63:0] f;
            f = {49'd0, freq};
            return 32'((f << 32) / SAMPLE_RATE);
        endfunction

        function logic [63:0] abs_phase(logic [31:0] p);
            logic [31:0] n;
            n = 32'd0 - p;
            return p[31] ? {32'd0, n} : {32'd0, p};
        endfunction

        function void apply_write(reg_idx_t idx, logic [CFG_W-1:0] data);
            logic [FREQ_W-1:0] f;
            shape_t            sh;
            f  = data[FREQ_W-1:0];
            sh = data[2:0];
            case (idx)
                REG_FREQUENCY:
                    if (f >= 1 && f <= 22000)
                        freq = f;
                REG_SHAPE:
                    if (sh <= SHAPE_SEQUENCE)
                    begin
                        case (sh)
                            SHAPE_SINE:     sine_ph   = 32'd0;
                            SHAPE_SQUARE:   square_ph = 32'd0;
                            SHAPE_TRIANGLE: tri_ph    = HALF;
                            SHAPE_SAWTOOTH: saw_ph    = HALF;
                            SHAPE_SEQUENCE: seq_state = SEQ_WAIT;
                            default: ;
                        endcase
                        shape = sh;
                    end
                REG_AMPLITUDE:
                    if (data <= 17'd65536)
                        gain = data;
                default: ;
            endcase
        endfunction

        function void note_word(logic [31:0] t, logic lb);
            logic [31:0]      inc;
            logic [31:0]      elapsed;
            logic [63:0]      g;
            logic [63:0]      a;
            logic [63:0]      m;
            bit               neg;
            logic [DAC_W-1:0] r;
            inc = phase_inc();
            g   = {47'd0, gain};
            r   = MID[DAC_W-1:0];
            case (shape)
                SHAPE_SINE:
                begin
                    r = sine_code();
                    sine_ph += inc;
                end
                SHAPE_SQUARE:
                begin
                    r = centered_code(MID * g, square_ph[31], 16);
                    square_ph += inc;
                end
                SHAPE_TRIANGLE:
                begin
                    a   = abs_phase(tri_ph);
                    neg = a > Q30;
                    m   = neg ? a - Q30 : Q30 - a;
                    r   = centered_code(MID * m * g, neg, 46);
                    tri_ph += inc;
                end
                SHAPE_SAWTOOTH:
                begin
                    r = centered_code(FULL * abs_phase(saw_ph) * g, saw_ph[31], 48);
                    saw_ph += inc;
                end
                SHAPE_SEQUENCE:
                begin
                    elapsed = t - pulse_start;
                    if (seq_state == SEQ_BURST)
                    begin
                        r = sine_code();
                        sine_ph += inc;
                    end
                    if (lb)
                    begin
                        case (seq_state)
                            SEQ_WAIT:
                            begin
                                sine_ph     = 32'd0;
                                pulse_start = t;
                                seq_state   = SEQ_LEAD;
                            end
                            SEQ_LEAD:
                                if (elapsed > 100) seq_state = SEQ_BURST;
                            SEQ_BURST:
                                if (elapsed > 105) seq_state = SEQ_TAIL;
                            default:
                                if (elapsed > 1000) seq_state = SEQ_WAIT;
                        endcase
                    end
                end
                default: ;
            endcase
            expected_codes.push_back(r);
        endfunction

        function void check_code(logic [DAC_W-1:0] code);
            logic [DAC_W-1:0] want;
            if (expected_codes.size() == 0)
            begin
                $error("dac_code with no expected word: expected none actual %0d", code);
                errors++;
                return;
            end
            want = expected_codes.pop_front();
            if (code !== want)
            begin
                $error("dac_code mismatch: expected %0d actual %0d", want, code);
                errors++;
            end
        endfunction

        function int pending();
            return expected_codes.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    reg_idx_t           cfg_index = REG_FREQUENCY;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [TIME_W-1:0]  now_ms = '0;
    logic               last_of_buffer = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [DAC_W-1:0]   dac_code;

    dac_sample_board sb = new();

    int send_idle_pct = 7;
    int recv_idle_pct = 63;
    int hold_reqs     = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    multi_shape_waveform_generator #(
        .SAMPLE_RATE_HZ   (SAMPLE_RATE),
        .DAC_FULL_SCALE   (FULL_SCALE),
        .SINE_TABLE_DEPTH (TABLE_DEPTH)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .now_ms         (now_ms),
        .last_of_buffer (last_of_buffer),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .dac_code       (dac_code)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (hold_served < hold_reqs)
        begin
            hold_left = HOLD_CYCLES;
            hold_served++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_code(dac_code);
    end

    task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.apply_write(idx, data);
        repeat ((idx == REG_FREQUENCY) ? DIVIDE_CYCLES : 1) @(posedge clk);
    endtask

    task automatic send_word(logic [TIME_W-1:0] t, logic lb);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        now_ms         <= t;
        last_of_buffer <= lb;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(t, lb);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [TIME_W-1:0] clock_ms;
        int                tmax;
        int                blen;
        int                fill;
        int                r;
        logic              lb;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: power-on settings, every shape but the sequence, register extremes and rejects
        repeat (2) send_word($urandom, 1'($urandom_range(0, 1)));
        drain();
        write_reg(REG_AMPLITUDE, 17'd65536);
        write_reg(REG_SHAPE, 17'(SHAPE_SQUARE));
        write_reg(REG_FREQUENCY, 17'd22000);
        repeat (3) send_word($urandom, 1'b0);
        drain();
        write_reg(REG_SHAPE, 17'(SHAPE_TRIANGLE));
        repeat (3) send_word($urandom, 1'b1);
        drain();
        write_reg(REG_SHAPE, 17'(SHAPE_SAWTOOTH));
        repeat (3) send_word($urandom, 1'b0);
        drain();
        write_reg(REG_SHAPE, 17'(SHAPE_SILENCE));
        send_word($urandom, 1'b1);
        drain();
        write_reg(REG_AMPLITUDE, 17'd0);
        write_reg(REG_SHAPE, 17'(SHAPE_SINE));
        repeat (2) send_word($urandom, 1'b0);
        drain();
        write_reg(REG_SHAPE, 17'd6);
        write_reg(REG_SHAPE, 17'd7);
        write_reg(REG_AMPLITUDE, 17'd65537);
        write_reg(reg_idx_t'(3), 17'h1FFFF);
        write_reg(REG_FREQUENCY, 17'd0);
        write_reg(REG_FREQUENCY, 17'd22001);
        write_reg(REG_FREQUENCY, 17'h1FFFF);
        send_word($urandom, 1'b0);
        drain();
        write_reg(REG_AMPLITUDE, 17'd65536);
        write_reg(REG_FREQUENCY, 17'h10001);
        repeat (2) send_word($urandom, 1'b1);
        drain();

        // directed: pulse sequence across the millisecond wrap
        write_reg(REG_SHAPE, 17'(SHAPE_SEQUENCE));
        write_reg(REG_FREQUENCY, 17'd12000);
        send_word(SEQ_BASE_MS, 1'b1);
        send_word(SEQ_BASE_MS + 100, 1'b1);
        send_word(SEQ_BASE_MS + 101, 1'b1);
        send_word(SEQ_BASE_MS + 101, 1'b0);
        send_word(SEQ_BASE_MS + 106, 1'b1);
        send_word(SEQ_BASE_MS + 1000, 1'b1);
        send_word(SEQ_BASE_MS + 1001, 1'b1);
        send_word(SEQ_BASE_MS + 1001, 1'b0);
        drain();

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            send_idle_pct = (ph < 4) ? 7 : (ph < 8) ? 63 : 0;
            recv_idle_pct = (ph < 4) ? 63 : (ph < 8) ? 7 : 0;

            r = $urandom_range(0, 9);
            if (r < 3)
                write_reg(REG_SHAPE, 17'(SHAPE_SEQUENCE));
            else if (r == 3)
                write_reg(REG_SHAPE, 17'($urandom_range(0, 7)));
            else
                write_reg(REG_SHAPE, 17'($urandom_range(0, 5)));

            r = $urandom_range(0, 7);
            case (r)
                0:       write_reg(REG_AMPLITUDE, 17'd0);
                1:       write_reg(REG_AMPLITUDE, 17'd65536);
                2:       write_reg(REG_AMPLITUDE, 17'($urandom));
                default: write_reg(REG_AMPLITUDE, 17'($urandom_range(0, 65536)));
            endcase

            if ($urandom_range(0, 3) == 0)
                write_reg(reg_idx_t'(3), 17'($urandom));

            r = $urandom_range(0, 7);
            case (r)
                0:       write_reg(REG_FREQUENCY, 17'd1);
                1:       write_reg(REG_FREQUENCY, 17'd22000);
                2:       write_reg(REG_FREQUENCY, 17'($urandom));
                default: write_reg(REG_FREQUENCY, 17'($urandom_range(1, 22000)));
            endcase

            if (ph == 2 || ph == 9)
                hold_reqs++;

            clock_ms = $urandom;
            r        = $urandom_range(0, 2);
            tmax     = (r == 0) ? 3 : (r == 1) ? 12 : 30;
            blen     = $urandom_range(1, 8);
            fill     = 0;
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                clock_ms += $urandom_range(0, tmax);
                fill++;
                lb = (fill >= blen);
                if (lb)
                    fill = 0;
                if ($urandom_range(0, 15) == 0)
                    send_word($urandom, 1'($urandom_range(0, 1)));
                else
                    send_word(clock_ms, lb);
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== multi_shape_waveform_generator.f =====
hw/rtl/mswg_pkg.sv
hw/rtl/mswg_front.sv
hw/rtl/mswg_queue.sv
hw/rtl/mswg_back.sv
hw/rtl/multi_shape_waveform_generator.sv
tb/tb_multi_shape_waveform_generator.sv
